/* rtl/prb_pkg.sv */
// Shared types and constants for the packet reorder buffer.
// Used by prb_slot_store and packet_reorder_buffer; depends on nothing.
package prb_pkg;

    localparam int BUFFER_DEPTH = 8;
    localparam int IDX_W        = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUFFER_DEPTH - 1);

    localparam int SEQ_W     = 16;
    localparam int CHAN_W    = 5;
    localparam int PAYLOAD_W = 64;
    localparam int STAT_W    = 2;
    localparam int DATA_W    = 88;

    localparam logic [STAT_W-1:0] STAT_DELIVERED = 2'd0;
    localparam logic [STAT_W-1:0] STAT_STORED    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;

    typedef struct packed {
        logic [SEQ_W-1:0]     seq;
        logic [CHAN_W-1:0]    chan;
        logic [PAYLOAD_W-1:0] payload;
    } entry_t;

    typedef struct packed {
        logic             write;
        logic             clear;
        logic [IDX_W-1:0] idx;
        entry_t           entry;
    } slot_cmd_t;

    typedef struct packed {
        logic   valid;
        logic   match;
        entry_t entry;
    } slot_rsp_t;

endpackage

/* rtl/prb_slot_store.sv */
// Slot storage of the reorder buffer with the shared sequence comparator.
// Depends on prb_pkg.
module prb_slot_store (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  prb_pkg::slot_cmd_t      cmd,
    input  logic [prb_pkg::SEQ_W-1:0] expected,
    output prb_pkg::slot_rsp_t      rsp
);
    import prb_pkg::*;

    logic [BUFFER_DEPTH-1:0] valid_reg;
    entry_t                  entry_reg [BUFFER_DEPTH];

    // Valid bits are cleared by reset; entry contents are only read while valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (cmd.write) begin
            valid_reg[cmd.idx] <= 1'b1;
        end else if (cmd.clear) begin
            valid_reg[cmd.idx] <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.write) begin
            entry_reg[cmd.idx] <= cmd.entry;
        end
    end

    // One slot is examined per cycle at the sequencer's index.
    always_comb begin
        rsp.valid = valid_reg[cmd.idx];
        rsp.entry = entry_reg[cmd.idx];
        rsp.match = valid_reg[cmd.idx] && (entry_reg[cmd.idx].seq == expected);
    end

endmodule

/* rtl/packet_reorder_buffer.sv */
// Top level of the packet reorder buffer: sequencer, expected count and output register.
// Depends on prb_pkg and prb_slot_store.
//
// Channel  Direction  Handshake          Contents
// s_       in         s_tvalid/s_tready  s_tdata: seq_num, channel, payload
// m_       out        m_tvalid/m_tready  m_tdata: out_seq, out_channel, out_payload;
//                                        m_tuser: status; m_tlast: last_of_run
//
// For a packet that is stored or dropped, a free slot is searched one slot per cycle
// by its valid bit. For a delivered packet, the buffer is rescanned from slot 0
// after each drained entry. Reset is synchronous and active low; it clears the delivered
// count, all slot valid bits, the sequencer and the valid bit of the output register.
// A stalled result channel holds the sequencer only when a new result must be handed
// over; the input is taken again as soon as the last result of a packet sits in the
// output register.
module packet_reorder_buffer (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // [15:0] seq_num, [20:16] channel, [84:21] payload, [87:85] zero
    input  logic [prb_pkg::DATA_W-1:0] s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // [15:0] out_seq, [20:16] out_channel, [84:21] out_payload, [87:85] zero
    output logic [prb_pkg::DATA_W-1:0] m_tdata,
    // [1:0] status
    output logic [prb_pkg::STAT_W-1:0] m_tuser,
    output logic                       m_tlast
);
    import prb_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FREE = 2'd2;
    localparam logic [1:0] S_LAST = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [SEQ_W-1:0]  dcount_reg, dcount_next;
    logic [STAT_W-1:0] pend_stat_reg, pend_stat_next;
    entry_t            pend_entry_reg, pend_entry_next;

    logic              m_valid_reg;
    logic [STAT_W-1:0] m_stat_reg;
    entry_t            m_entry_reg;
    logic              m_last_reg;

    logic              load_out;
    logic              load_last;
    logic              out_free;
    logic [SEQ_W-1:0]  expected;
    entry_t            in_entry;
    slot_cmd_t         cmd;
    slot_rsp_t         rsp;

    assign expected = dcount_reg + SEQ_W'(1);
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);

    assign in_entry.seq     = s_tdata[SEQ_W-1:0];
    assign in_entry.chan    = s_tdata[SEQ_W+CHAN_W-1:SEQ_W];
    assign in_entry.payload = s_tdata[SEQ_W+CHAN_W+PAYLOAD_W-1:SEQ_W+CHAN_W];

    prb_slot_store u_slots (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .expected (expected),
        .rsp      (rsp)
    );

    // The pending result is held back until the scan shows whether another
    // delivery follows it, so that the last result of a packet can be marked.
    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        dcount_next     = dcount_reg;
        pend_stat_next  = pend_stat_reg;
        pend_entry_next = pend_entry_reg;
        load_out        = 1'b0;
        load_last       = 1'b0;
        cmd.write       = 1'b0;
        cmd.clear       = 1'b0;
        cmd.idx         = idx_reg;
        cmd.entry       = pend_entry_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    pend_entry_next = in_entry;
                    idx_next        = '0;
                    if (in_entry.seq == expected) begin
                        pend_stat_next = STAT_DELIVERED;
                        dcount_next    = in_entry.seq;
                        state_next     = S_SCAN;
                    end else begin
                        pend_stat_next = STAT_STORED;
                        state_next     = S_FREE;
                    end
                end
            end
            S_SCAN: begin
                if (rsp.match) begin
                    // Hand over the pending delivery, then restart the scan so
                    // that the lowest matching slot is always taken first.
                    if (out_free) begin
                        load_out        = 1'b1;
                        pend_entry_next = rsp.entry;
                        dcount_next     = rsp.entry.seq;
                        cmd.clear       = 1'b1;
                        idx_next        = '0;
                    end
                end else if (idx_reg == LAST_IDX) begin
                    state_next = S_LAST;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_FREE: begin
                if (!rsp.valid) begin
                    cmd.write               = 1'b1;
                    pend_entry_next.payload = '0;
                    state_next              = S_LAST;
                end else if (idx_reg == LAST_IDX) begin
                    pend_stat_next          = STAT_FULL;
                    pend_entry_next.payload = '0;
                    state_next              = S_LAST;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_LAST: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    load_last  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            idx_reg     <= '0;
            dcount_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            dcount_reg <= dcount_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pend_stat_reg  <= pend_stat_next;
        pend_entry_reg <= pend_entry_next;
        if (load_out) begin
            m_stat_reg  <= pend_stat_reg;
            m_entry_reg <= pend_entry_reg;
            m_last_reg  <= load_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_stat_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {(DATA_W - SEQ_W - CHAN_W - PAYLOAD_W)'(0),
                       m_entry_reg.payload, m_entry_reg.chan, m_entry_reg.seq};

endmodule
